@@ src/cbor_item_skip_parser_macros.svh @@
// Assertion macros for the CBOR item skip parser.
// Each macro expects clk and rst_n in scope of the module that includes it.
`ifndef CBOR_ITEM_SKIP_PARSER_MACROS_SVH
`define CBOR_ITEM_SKIP_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define CIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/cis_pkg.sv @@
// Shared types and constants of the CBOR item skip parser.
// No dependencies; imported by cis_front, cis_core and the top level.
package cis_pkg;

  localparam logic [2:0] MAJ_BSTR   = 3'd2;
  localparam logic [2:0] MAJ_TSTR   = 3'd3;
  localparam logic [2:0] MAJ_ARRAY  = 3'd4;
  localparam logic [2:0] MAJ_MAP    = 3'd5;
  localparam logic [2:0] MAJ_SIMPLE = 3'd7;

  localparam logic [4:0] INFO_FALSE    = 5'd20;
  localparam logic [4:0] INFO_NULL     = 5'd22;
  localparam logic [4:0] INFO_ARG8     = 5'd24;
  localparam logic [4:0] INFO_FLOAT32  = 5'd26;
  localparam logic [4:0] INFO_FLOAT64  = 5'd27;
  localparam logic [4:0] INFO_RESERVED = 5'd28;

  localparam logic [4:0] NEST_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_BUSY      = 3'd0,
    ST_ITEM_DONE = 3'd1,
    ST_INVALID   = 3'd2,
    ST_END       = 3'd3,
    ST_TOO_DEEP  = 3'd4,
    ST_TOO_LARGE = 3'd5
  } status_t;

  // Classified input byte, front to back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       eob;
    logic [2:0] maj;
    logic [4:0] info;
    logic       reserved;
    logic       simple_ok;
    logic       is_float;
    logic       short_arg;
    logic [3:0] arg_len;
  } cls_t;

  // One result transaction.
  typedef struct packed {
    status_t     status;
    logic [2:0]  major_type;
    logic [31:0] item_length;
  } res_t;

endpackage

@@ src/cis_fifo.sv @@
// Two-entry queue with push/full and pop/empty sides.
// Depends on nothing; payload width set by WIDTH.
module cis_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ src/cis_front.sv @@
// Front end: accepts input bytes, splits heads into major type and info
// and queues the classified byte. Depends on cis_pkg and cis_fifo.
module cis_front
  import cis_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       end_of_buffer,
  input  logic       pop,
  output logic       empty,
  output cls_t       item
);

  cls_t cls;

  always_comb begin
    cls.data_byte = data_byte;
    cls.eob       = end_of_buffer;
    cls.maj       = data_byte[7:5];
    cls.info      = data_byte[4:0];
    cls.reserved  = (cls.info >= INFO_RESERVED);
    cls.simple_ok = (cls.info >= INFO_FALSE) && (cls.info <= INFO_NULL);
    cls.is_float  = (cls.info == INFO_FLOAT32) || (cls.info == INFO_FLOAT64);
    cls.short_arg = (cls.info < INFO_ARG8);
    // argument byte count: 1, 2, 4 or 8; floats map onto the same codes
    case (cls.info[1:0])
      2'd0:    cls.arg_len = 4'd1;
      2'd1:    cls.arg_len = 4'd2;
      2'd2:    cls.arg_len = 4'd4;
      default: cls.arg_len = 4'd8;
    endcase
  end

  cis_fifo #(.WIDTH($bits(cls_t))) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .wr_data (cls),
    .pop     (pop),
    .empty   (empty),
    .rd_data (item)
  );

endmodule

@@ src/cis_core.sv @@
// Back end: parser state, argument/payload counters and container stack.
// Depends on cis_pkg and the assertion macro header.
`include "cbor_item_skip_parser_macros.svh"
module cis_core
  import cis_pkg::*;
#(
  parameter int STACK_DEPTH = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [4:0] nesting_limit,
  input  logic       in_valid,
  input  cls_t       in_item,
  output logic       in_pop,
  input  logic       out_full,
  output logic       out_push,
  output res_t       out_res
);

  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [1:0] {PH_HEAD, PH_ARG, PH_PAYLOAD} phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             left_r, left_nxt;
  logic [63:0]            arg_r, arg_nxt;
  logic [2:0]             pmaj_r, pmaj_nxt;
  logic [COUNT_WIDTH-1:0] payload_r, payload_nxt;
  logic [LW-1:0]          level_r, level_nxt;
  logic [2:0]             top_r, top_nxt;
  logic [31:0]            bytes_r, bytes_nxt, bytes_inc;

  logic [COUNT_WIDTH-1:0] cnt_r  [STACK_DEPTH];
  logic                   map_r  [STACK_DEPTH];
  logic                   pend_r [STACK_DEPTH];

  logic             step;
  status_t          st;
  logic             tk_valid, fin_req, open_lvl, too_large;
  logic [2:0]       tk_maj;
  logic [63:0]      tk_val;
  logic [STACK_DEPTH-1:0] stop;
  logic             fin_any;
  logic [IW-1:0]    fin_idx;
  logic [7:0]       lim;

  assign step     = in_valid && !out_full;
  assign in_pop   = step;
  assign out_push = step;

  always_comb begin
    if (nesting_limit == 5'd0) lim = 8'd1;
    else if (8'(nesting_limit) > 8'(STACK_DEPTH)) lim = 8'(STACK_DEPTH);
    else lim = 8'(nesting_limit);
  end

  // highest open level that absorbs the finished item
  always_comb begin
    fin_any = 1'b0;
    fin_idx = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      stop[i] = (i < int'(level_r)) &&
                ((map_r[i] && !pend_r[i]) || (cnt_r[i] != COUNT_WIDTH'(1)));
      if (stop[i]) begin
        fin_any = 1'b1;
        fin_idx = IW'(i);
      end
    end
  end

  assign bytes_inc = (bytes_r == 32'hFFFF_FFFF) ? bytes_r : bytes_r + 32'd1;

  always_comb begin
    phase_nxt   = phase_r;
    left_nxt    = left_r;
    arg_nxt     = arg_r;
    pmaj_nxt    = pmaj_r;
    payload_nxt = payload_r;
    level_nxt   = level_r;
    top_nxt     = top_r;
    bytes_nxt   = bytes_inc;
    st          = ST_BUSY;
    tk_valid    = 1'b0;
    tk_maj      = in_item.maj;
    tk_val      = 64'(in_item.info);
    fin_req     = 1'b0;
    open_lvl    = 1'b0;

    unique case (phase_r)
      PH_ARG: begin
        arg_nxt = {arg_r[55:0], in_item.data_byte};
        if (left_r != 4'd0) left_nxt = left_r - 4'd1;
        if (left_r <= 4'd1) begin
          phase_nxt = PH_HEAD;
          tk_valid  = 1'b1;
          tk_maj    = pmaj_r;
          tk_val    = arg_nxt;
        end
      end
      PH_PAYLOAD: begin
        payload_nxt = payload_r - COUNT_WIDTH'(1);
        if (payload_nxt == '0) begin
          phase_nxt = PH_HEAD;
          fin_req   = 1'b1;
        end
      end
      default: begin
        if (level_r == '0) top_nxt = in_item.maj;
        if (in_item.reserved) begin
          st = ST_INVALID;
        end else if (in_item.maj == MAJ_SIMPLE) begin
          if (in_item.simple_ok) begin
            fin_req = 1'b1;
          end else if (in_item.is_float) begin
            phase_nxt = PH_ARG;
            left_nxt  = in_item.arg_len;
            arg_nxt   = '0;
            pmaj_nxt  = MAJ_SIMPLE;
          end else begin
            st = ST_INVALID;
          end
        end else if (in_item.short_arg) begin
          tk_valid = 1'b1;
        end else begin
          phase_nxt = PH_ARG;
          left_nxt  = in_item.arg_len;
          arg_nxt   = '0;
          pmaj_nxt  = in_item.maj;
        end
      end
    endcase

    too_large = (COUNT_WIDTH < 64) && (|(tk_val >> COUNT_WIDTH));

    if (tk_valid) begin
      case (tk_maj) inside
        MAJ_BSTR, MAJ_TSTR: begin
          if (too_large) st = ST_TOO_LARGE;
          else if (tk_val == 64'd0) fin_req = 1'b1;
          else begin
            payload_nxt = tk_val[COUNT_WIDTH-1:0];
            phase_nxt   = PH_PAYLOAD;
          end
        end
        MAJ_ARRAY, MAJ_MAP: begin
          if (too_large) st = ST_TOO_LARGE;
          else if (tk_val == 64'd0) fin_req = 1'b1;
          else if (8'(level_r) >= lim) st = ST_TOO_DEEP;
          else begin
            open_lvl  = 1'b1;
            level_nxt = level_r + LW'(1);
          end
        end
        default: fin_req = 1'b1;
      endcase
    end

    if (fin_req) begin
      if (!fin_any) st = ST_ITEM_DONE;
      else level_nxt = LW'(fin_idx) + LW'(1);
    end

    if (st == ST_BUSY && in_item.eob) begin
      st = (phase_nxt == PH_PAYLOAD) ? ST_INVALID : ST_END;
    end

    out_res.status      = st;
    out_res.major_type  = top_nxt;
    out_res.item_length = bytes_inc;

    // any final status drops back to a fresh top-level item
    if (st != ST_BUSY) begin
      phase_nxt   = PH_HEAD;
      left_nxt    = 4'd0;
      payload_nxt = '0;
      level_nxt   = '0;
      bytes_nxt   = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEAD;
      left_r    <= 4'd0;
      arg_r     <= 64'd0;
      pmaj_r    <= 3'd0;
      payload_r <= '0;
      level_r   <= '0;
      top_r     <= 3'd0;
      bytes_r   <= 32'd0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      left_r    <= left_nxt;
      arg_r     <= arg_nxt;
      pmaj_r    <= pmaj_nxt;
      payload_r <= payload_nxt;
      level_r   <= level_nxt;
      top_r     <= top_nxt;
      bytes_r   <= bytes_nxt;
    end
  end

  // stack contents: written on open, updated where an item lands
  always_ff @(posedge clk) begin
    if (step && open_lvl) begin
      cnt_r[level_r[IW-1:0]]  <= tk_val[COUNT_WIDTH-1:0];
      map_r[level_r[IW-1:0]]  <= (tk_maj == MAJ_MAP);
      pend_r[level_r[IW-1:0]] <= 1'b0;
    end else if (step && fin_req && fin_any && st == ST_BUSY) begin
      if (map_r[fin_idx] && !pend_r[fin_idx]) begin
        pend_r[fin_idx] <= 1'b1;
      end else begin
        pend_r[fin_idx] <= 1'b0;
        cnt_r[fin_idx]  <= cnt_r[fin_idx] - COUNT_WIDTH'(1);
      end
    end
  end

  `CIS_ASSERT_NOW(a_level_bound, 1'b1, int'(level_r) <= STACK_DEPTH, "stack level overflow")
  `CIS_ASSERT_NEXT(a_final_clears, step && st != ST_BUSY, level_r == '0 && phase_r == PH_HEAD && bytes_r == 32'd0, "final status did not clear state")
  `CIS_ASSERT_NOW(a_arg_count, phase_r == PH_ARG, left_r != 4'd0, "argument phase with no bytes left")
  `CIS_ASSERT_NOW(a_payload_count, phase_r == PH_PAYLOAD, payload_r != '0, "payload phase with no bytes left")

endmodule

@@ src/cbor_item_skip_parser.sv @@
// CBOR item skip parser: takes one byte of a CBOR stream per transaction
// and returns one result transaction per byte: status (busy, item complete,
// invalid, end of data, too deep, length too large), the major type of the
// current top-level item and its byte count so far. Throughput is one byte
// per clock while the result queue is not full; a byte passes a two-entry
// input queue, the parser stage and a two-entry result queue. An accepted
// byte is registered in the input queue, parsed at its head and its result
// registered in the result queue. Container unwinding is a combinational
// priority find over the stack levels. The user must write nesting_limit
// through cfg_we/cfg_nesting_limit only while the block is idle; the block
// does not enforce this. It resets to 16 and is clamped to 1..STACK_DEPTH.
// Depends on cis_pkg, cis_front, cis_core and cis_fifo.
module cbor_item_skip_parser
  import cis_pkg::*;
#(
  parameter int STACK_DEPTH = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input transactions
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_buffer,
  // result transactions
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_status,
  output logic [2:0]  out_major_type,
  output logic [31:0] out_item_length,
  // configuration
  input  logic        cfg_we,
  input  logic [4:0]  cfg_nesting_limit
);

  logic [4:0] nest_r;
  cls_t       item;
  logic       item_empty, item_pop;
  logic       res_full, res_push;
  res_t       res, res_head;

  // hold the nesting limit; write it only while no transaction is in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nest_r <= NEST_RESET;
    end else if (cfg_we) begin
      nest_r <= cfg_nesting_limit;
    end
  end

  cis_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .data_byte     (in_data_byte),
    .end_of_buffer (in_end_of_buffer),
    .pop           (item_pop),
    .empty         (item_empty),
    .item          (item)
  );

  cis_core #(
    .STACK_DEPTH (STACK_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .nesting_limit (nest_r),
    .in_valid      (!item_empty),
    .in_item       (item),
    .in_pop        (item_pop),
    .out_full      (res_full),
    .out_push      (res_push),
    .out_res       (res)
  );

  // result queue decouples the parser from a stalled consumer
  cis_fifo #(.WIDTH($bits(res_t))) u_res_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .full    (res_full),
    .wr_data (res),
    .pop     (pop),
    .empty   (empty),
    .rd_data (res_head)
  );

  assign out_status      = res_head.status;
  assign out_major_type  = res_head.major_type;
  assign out_item_length = res_head.item_length;

endmodule

@@ tb/cbor_item_skip_parser_tb.sv @@
// Testbench for the CBOR item skip parser: directed byte table, then random
// well-formed CBOR streams with noise, checked against a behavioral model.
// Depends on cis_pkg and the cbor_item_skip_parser RTL.
`timescale 1ns / 100ps

module cbor_item_skip_parser_tb;
  import cis_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [31:0] LEN_SAT = 32'hFFFF_FFFF;

  // Parser phases of the model.
  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_ARG = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct {
    logic [7:0] data_byte;
    logic eob;
    logic chk;
    status_t status;
    logic [2:0] major_type;
    logic [31:0] item_length;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [7:0] in_data_byte = '0;
  logic in_end_of_buffer = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [2:0] out_status;
  logic [2:0] out_major_type;
  logic [31:0] out_item_length;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_nesting_limit = NEST_RESET;

  always #5 clk = ~clk;

  cbor_item_skip_parser DUT (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_data_byte(in_data_byte), .in_end_of_buffer(in_end_of_buffer),
    .empty(empty), .pop(pop),
    .out_status(out_status), .out_major_type(out_major_type),
    .out_item_length(out_item_length),
    .cfg_we(cfg_we), .cfg_nesting_limit(cfg_nesting_limit)
  );

  // Model state.
  logic [4:0] nest_lim;
  phase_t ph;
  logic [3:0] arg_left;
  logic [63:0] arg_val;
  logic [2:0] pend_maj;
  logic [31:0] pay_left;
  logic [31:0] lvl_cnt [DEPTH];
  logic lvl_map [DEPTH];
  logic lvl_val [DEPTH];
  int lvl;
  logic [2:0] top_maj;
  logic [31:0] seen;

  res_t expected_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int status_hits [6];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 1'b0;

  function automatic status_t close_item();
    int i;
    while (lvl > 0) begin
      i = lvl - 1;
      if (lvl_map[i] && !lvl_val[i]) begin
        lvl_val[i] = 1'b1;
        return ST_BUSY;
      end
      lvl_val[i] = 1'b0;
      lvl_cnt[i] = lvl_cnt[i] - 1;
      if (lvl_cnt[i] != 0) return ST_BUSY;
      lvl--;
    end
    return ST_ITEM_DONE;
  endfunction

  function automatic status_t apply_arg(logic [2:0] maj, logic [63:0] v);
    int lim;
    lim = (nest_lim < 1) ? 1 : (nest_lim > DEPTH) ? DEPTH : nest_lim;
    if (maj == MAJ_BSTR || maj == MAJ_TSTR) begin
      if (v > 64'hFFFF_FFFF) return ST_TOO_LARGE;
      if (v == 0) return close_item();
      pay_left = v[31:0];
      ph = PH_PAYLOAD;
      return ST_BUSY;
    end
    if (maj == MAJ_ARRAY || maj == MAJ_MAP) begin
      if (v > 64'hFFFF_FFFF) return ST_TOO_LARGE;
      if (v == 0) return close_item();
      if (lvl >= lim) return ST_TOO_DEEP;
      lvl_cnt[lvl] = v[31:0];
      lvl_map[lvl] = (maj == MAJ_MAP);
      lvl_val[lvl] = 1'b0;
      lvl++;
      return ST_BUSY;
    end
    return close_item();
  endfunction

  function automatic void model_reset();
    nest_lim = NEST_RESET;
    ph = PH_HEAD;
    arg_left = '0;
    arg_val = '0;
    pend_maj = '0;
    pay_left = '0;
    lvl = 0;
    top_maj = '0;
    seen = '0;
  endfunction

  // Advance the model by one byte; return the expected result.
  function automatic res_t parse_byte(logic [7:0] b, logic eob);
    status_t st;
    logic [2:0] maj;
    logic [4:0] info;
    res_t r;
    st = ST_BUSY;
    if (seen < LEN_SAT) seen++;
    if (ph == PH_ARG) begin
      arg_val = {arg_val[55:0], b};
      if (arg_left > 0) arg_left--;
      if (arg_left == 0) begin
        ph = PH_HEAD;
        st = apply_arg(pend_maj, arg_val);
      end
    end else if (ph == PH_PAYLOAD) begin
      pay_left--;
      if (pay_left == 0) begin
        ph = PH_HEAD;
        st = close_item();
      end
    end else begin
      maj = b[7:5];
      info = b[4:0];
      if (lvl == 0) top_maj = maj;
      if (info >= INFO_RESERVED) st = ST_INVALID;
      else if (maj == MAJ_SIMPLE) begin
        if (info >= INFO_FALSE && info <= INFO_NULL) st = close_item();
        else if (info == INFO_FLOAT32 || info == INFO_FLOAT64) begin
          ph = PH_ARG;
          arg_left = (info == INFO_FLOAT32) ? 4'd4 : 4'd8;
          arg_val = '0;
          pend_maj = MAJ_SIMPLE;
        end else st = ST_INVALID;
      end else if (info < INFO_ARG8) st = apply_arg(maj, 64'(info));
      else begin
        ph = PH_ARG;
        arg_left = 4'(1 << (info - INFO_ARG8));
        arg_val = '0;
        pend_maj = maj;
      end
    end
    if (st == ST_BUSY && eob) st = (ph == PH_PAYLOAD) ? ST_INVALID : ST_END;
    r.status = st;
    r.major_type = top_maj;
    r.item_length = seen;
    if (st != ST_BUSY) begin
      ph = PH_HEAD;
      arg_left = '0;
      pay_left = '0;
      lvl = 0;
      seen = '0;
    end
    return r;
  endfunction

  // Offer one byte until accepted; optional idle cycles before it.
  // Called at a rising edge; returns at the edge that accepted the byte.
  task automatic send_byte(logic [7:0] b, logic eob);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_data_byte <= b;
    in_end_of_buffer <= eob;
    do @(posedge clk); while (full);
    // Accepted at this edge: keep push up so the next byte can follow at once.
    expected_results.push_back(parse_byte(b, eob));
    items_sent++;
  endtask

  task automatic send_typed(row_t r);
    res_t e;
    send_byte(r.data_byte, r.eob);
    if (r.chk) begin
      e = expected_results[$];
      if (e.status !== r.status || e.major_type !== r.major_type ||
          e.item_length !== r.item_length) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row %h: model gives %0d/%0d/%0d, table %0d/%0d/%0d",
                   r.data_byte, e.status, e.major_type, e.item_length,
                   r.status, r.major_type, r.item_length);
      end
    end
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    push <= 1'b0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(logic [4:0] v);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_nesting_limit <= v;
    nest_lim = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Emit a head with argument v using the shortest or a forced encoding.
  task automatic send_head(logic [2:0] maj, logic [63:0] v, logic eob_last);
    int n;
    if (v < 24) begin
      send_byte({maj, v[4:0]}, eob_last);
      return;
    end
    n = (v < 256) ? 0 : (v < 65536) ? 1 : (v < 64'h1_0000_0000) ? 2 : 3;
    if ($urandom_range(9) == 0 && n < 3) n++;
    send_byte({maj, 5'(INFO_ARG8 + n)}, 1'b0);
    for (int k = (1 << n) - 1; k >= 0; k--)
      send_byte(v[8*k +: 8], eob_last && k == 0);
  endtask

  // Random well-formed item, depth bounded.
  task automatic send_item(int d);
    int kind;
    int n;
    kind = $urandom_range(9);
    if (d >= 5 && kind >= 6) kind = 0;
    case (kind)
      0: send_head(3'd0, $urandom_range(3) == 0 ? {$urandom, $urandom} :
                   64'($urandom_range(300)), 1'b0);
      1: send_head(3'd1, 64'($urandom_range(70000)), 1'b0);
      2, 3: begin
        n = $urandom_range(6);
        send_head(kind == 2 ? MAJ_BSTR : MAJ_TSTR, 64'(n), 1'b0);
        repeat (n) send_byte(8'($urandom), 1'b0);
      end
      4: begin
        n = $urandom_range(3);
        if (n == 3) send_byte({MAJ_SIMPLE, INFO_FLOAT64}, 1'b0);
        else if (n == 2) send_byte({MAJ_SIMPLE, INFO_FLOAT32}, 1'b0);
        else send_byte({MAJ_SIMPLE, 5'(INFO_FALSE + $urandom_range(2))}, 1'b0);
        if (n >= 2) repeat (n == 3 ? 8 : 4) send_byte(8'($urandom), 1'b0);
      end
      5: send_head(3'd6, 64'($urandom_range(40)), 1'b0);
      6, 7: begin
        n = $urandom_range(3);
        send_head(MAJ_ARRAY, 64'(n), 1'b0);
        repeat (n) send_item(d + 1);
      end
      default: begin
        n = $urandom_range(2);
        send_head(MAJ_MAP, 64'(n), 1'b0);
        repeat (2 * n) send_item(d + 1);
      end
    endcase
  endtask

  // Receiver: pop at random, or hold off entirely while recv_hold is set.
  always @(posedge clk) begin
    pop <= rst_n && !recv_hold &&
           !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  // Compare each popped result with the oldest expectation.
  always @(posedge clk) begin
    res_t e;
    if (rst_n && pop && !empty) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d/%0d/%0d", out_status, out_major_type,
                   out_item_length);
      end else begin
        e = expected_results.pop_front();
        if (out_status <= ST_TOO_LARGE) status_hits[out_status]++;
        if (out_status !== e.status || out_major_type !== e.major_type ||
            out_item_length !== e.item_length) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     e.status, e.major_type, e.item_length,
                     out_status, out_major_type, out_item_length);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("timeout");
    $display("cbor_item_skip_parser_tb: done, errors");
    $finish;
  end

  row_t dir_rows[$];

  initial begin
    int phase_no;
    int sent_now;
    for (int s = 0; s < 6; s++) status_hits[s] = 0;
    model_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: status, top major and length typed in where obvious.
    dir_rows = '{
      '{8'h00, 1'b0, 1'b1, ST_ITEM_DONE, 3'd0, 32'd1},
      '{8'h17, 1'b0, 1'b1, ST_ITEM_DONE, 3'd0, 32'd1},
      '{8'h3C, 1'b0, 1'b1, ST_INVALID, 3'd1, 32'd1},
      '{8'hFF, 1'b0, 1'b1, ST_INVALID, 3'd7, 32'd1},
      '{8'hF4, 1'b0, 1'b1, ST_ITEM_DONE, 3'd7, 32'd1},
      '{8'hF6, 1'b0, 1'b1, ST_ITEM_DONE, 3'd7, 32'd1},
      '{8'hF7, 1'b0, 1'b1, ST_INVALID, 3'd7, 32'd1},
      '{8'hE0, 1'b0, 1'b1, ST_INVALID, 3'd7, 32'd1},
      '{8'h80, 1'b0, 1'b1, ST_ITEM_DONE, 3'd4, 32'd1},
      '{8'hA0, 1'b0, 1'b1, ST_ITEM_DONE, 3'd5, 32'd1},
      '{8'h40, 1'b0, 1'b1, ST_ITEM_DONE, 3'd2, 32'd1},
      '{8'hC5, 1'b0, 1'b1, ST_ITEM_DONE, 3'd6, 32'd1},
      '{8'h1B, 1'b0, 1'b1, ST_BUSY, 3'd0, 32'd1},
      '{8'hFF, 1'b0, 1'b0, ST_BUSY, 3'd0, 32'd0},
      '{8'hFF, 1'b0, 1'b0, ST_BUSY, 3'd0, 32'd0},
      '{8'h00, 1'b0, 1'b0, ST_BUSY, 3'd0, 32'd0},
      '{8'h00, 1'b0, 1'b0, ST_BUSY, 3'd0, 32'd0},
      '{8'hAA, 1'b0, 1'b0, ST_BUSY, 3'd0, 32'd0},
      '{8'h55, 1'b0, 1'b0, ST_BUSY, 3'd0, 32'd0},
      '{8'h00, 1'b0, 1'b0, ST_BUSY, 3'd0, 32'd0},
      '{8'h80, 1'b0, 1'b1, ST_ITEM_DONE, 3'd0, 32'd9},
      '{8'h5B, 1'b0, 1'b1, ST_BUSY, 3'd2, 32'd1},
      '{8'h01, 1'b0, 1'b0, ST_BUSY, 3'd2, 32'd0},
      '{8'h62, 1'b1, 1'b1, ST_END, 3'd2, 32'd3},
      '{8'h62, 1'b0, 1'b1, ST_BUSY, 3'd3, 32'd1},
      '{8'h41, 1'b1, 1'b1, ST_INVALID, 3'd3, 32'd2}
    };
    foreach (dir_rows[i]) send_typed(dir_rows[i]);
    // Length too large: 8-byte string length above 2^32-1, then a too-long array.
    send_byte(8'h5B, 1'b0);
    send_byte(8'h01, 1'b0);
    repeat (7) send_byte(8'h00, 1'b0);
    send_byte(8'h9B, 1'b0);
    repeat (3) send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    repeat (4) send_byte(8'h00, 1'b0);

    // Nesting at the extremes of the limit.
    for (int c = 0; c < 4; c++) begin
      write_limit(c == 0 ? 5'd1 : c == 1 ? 5'd0 : c == 2 ? 5'd31 : 5'd16);
      repeat (18) send_byte(8'h81, 1'b0);
      send_byte(8'h81, 1'b1);
    end

    // Random phases with different idling and limits.
    for (phase_no = 0; phase_no < 6; phase_no++) begin
      case (phase_no)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 88; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 88; end
        3: begin send_idle_pct = 6; recv_stall_pct = 6; end
        4: begin send_idle_pct = 0; recv_stall_pct = 0; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      write_limit(phase_no == 5 ? 5'd2 : 5'($urandom_range(1, 16)));
      sent_now = items_sent;
      // Hold off the receiver while bytes keep coming so the input backs up.
      if (phase_no == 4) fork
        begin
          recv_hold = 1'b1;
          repeat (60) @(posedge clk);
          recv_hold = 1'b0;
        end
      join_none
      while (items_sent - sent_now < 95) begin
        if ($urandom_range(9) < 8) send_item(0);
        else if ($urandom_range(1) == 0)
          send_byte(8'($urandom), $urandom_range(3) == 0);
        else begin
          // Truncated item: end of buffer mid-item.
          send_byte({3'($urandom_range(5)), 5'd25}, 1'b0);
          send_byte(8'($urandom), 1'b1);
        end
      end
      // Sender pause until everything has come back.
      wait_drained();
    end

    wait_drained();
    $display("covered %0d bytes, %0d results: done %0d invalid %0d end %0d",
             items_sent, results_seen, status_hits[1], status_hits[2], status_hits[3]);
    $display("too deep %0d, too large %0d, limits 0..31 incl. clamping",
             status_hits[4], status_hits[5]);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("cbor_item_skip_parser_tb: done, clean");
    else
      $display("cbor_item_skip_parser_tb: done, errors");
    $finish;
  end

endmodule
